>>> rtl/fnu_pkg.sv
// Shared constants and types of the furthest-next-use byte budget evictor.
package fnu_pkg;

	// Number of chunk slots and the index width that follows from it.
	localparam int NUM_CHUNKS = 64;
	localparam int IDX_W      = $clog2(NUM_CHUNKS);

	// Field widths.
	localparam int ID_W    = 6;
	localparam int SIZE_W  = 32;
	localparam int TIME_W  = 32;
	localparam int BYTES_W = 48;
	localparam int CNT_W   = 64;

	// Packed stream widths, rounded up to whole bytes.
	localparam int IN_W  = 72;
	localparam int OUT_W = 184;

	// Report kinds carried on tuser.
	localparam logic KIND_EVICT  = 1'b0;
	localparam logic KIND_ACCESS = 1'b1;

	// Result of one victim search.
	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] victim;
	} scan_res_t;

endpackage

>>> rtl/fnu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fnu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data register holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/fnu_scan.sv
// Victim search unit: walks the next-use RAM one entry per cycle with one shared comparator.
module fnu_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [fnu_pkg::NUM_CHUNKS-1:0]      present,
	input  logic [fnu_pkg::TIME_W-1:0]          rdata,
	output logic                                rd_en,
	output logic [fnu_pkg::IDX_W-1:0]           rd_addr,
	output fnu_pkg::scan_res_t                  res
);

	logic                         busy_q;
	logic [fnu_pkg::IDX_W:0]      cnt_q;
	logic                         vld_s1;
	logic [fnu_pkg::IDX_W-1:0]    idx_s1;
	logic                         found_q;
	logic [fnu_pkg::TIME_W-1:0]   best_q;
	logic [fnu_pkg::IDX_W-1:0]    victim_q;
	logic                         take;
	logic                         done;

	// Issue one read per cycle until every slot has been addressed.
	assign rd_en   = busy_q && (cnt_q < (fnu_pkg::IDX_W+1)'(fnu_pkg::NUM_CHUNKS));
	assign rd_addr = cnt_q[fnu_pkg::IDX_W-1:0];

	// A resident entry replaces the best only when strictly further, so ties keep the lowest id.
	assign take = vld_s1 && present[idx_s1] && (!found_q || (rdata > best_q));

	// The search ends once all reads are issued and the last one is compared.
	assign done = busy_q && !vld_s1 &&
		(cnt_q == (fnu_pkg::IDX_W+1)'(fnu_pkg::NUM_CHUNKS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
				if (done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Address pipeline and best-so-far payload.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (take) begin
			best_q   <= rdata;
			victim_q <= idx_s1;
		end
	end

	assign res.done   = done;
	assign res.victim = victim_q;

endmodule

>>> rtl/furthest_next_use_byte_budget_evictor_top.sv
// Top level of the furthest-next-use byte budget evictor: sequencer, stores and counters.
// Sequence: a hit registers its access outcome through LOOKUP and HIT, an unstored miss through
// LOOKUP and OUTCOME, a storing miss through LOOKUP, CHECK and STORE; each eviction adds SCAN,
// SIZE and EVICT, with the victim search reading the next-use RAM one entry per cycle through a single comparator.
// Throughput: one item in work at a time; the next is accepted the cycle after the final
// result is registered. Reset clears flags, resident bytes, counters and budget, not the RAMs.
module furthest_next_use_byte_budget_evictor_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: byte_budget.
	input  logic                          cfg_we,
	input  logic [fnu_pkg::BYTES_W-1:0]   cfg_wdata,
	// Input stream. tdata: chunk_id, chunk_size, next_use_time, zero pad.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fnu_pkg::IN_W-1:0]      s_tdata,
	// Output stream. tdata: victim_id, was_hit, too_large, bytes_resident, miss_total,
	// missed_byte_total. tuser: report_kind.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fnu_pkg::OUT_W-1:0]     m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_LOOKUP  = 9'b000000010,
		ST_HIT     = 9'b000000100,
		ST_OUTCOME = 9'b000001000,
		ST_CHECK   = 9'b000010000,
		ST_SCAN    = 9'b000100000,
		ST_SIZE    = 9'b001000000,
		ST_EVICT   = 9'b010000000,
		ST_STORE   = 9'b100000000
	} state_t;

	state_t                              state_q;
	logic [fnu_pkg::BYTES_W-1:0]         budget_q;
	logic [fnu_pkg::NUM_CHUNKS-1:0]      present_q;
	logic [fnu_pkg::BYTES_W-1:0]         occupied_q;
	logic [fnu_pkg::CNT_W-1:0]           miss_cnt_q;
	logic [fnu_pkg::CNT_W-1:0]           miss_bytes_q;
	logic [fnu_pkg::ID_W-1:0]            id_q;
	logic [fnu_pkg::SIZE_W-1:0]          size_q;
	logic [fnu_pkg::TIME_W-1:0]          nu_q;
	logic                                big_q;

	// Output register.
	logic                                out_vld_q;
	logic                                out_kind_q;
	logic                                out_last_q;
	logic [fnu_pkg::OUT_W-1:0]           out_data_q;
	logic                                out_kind_d;
	logic                                out_last_d;
	logic [fnu_pkg::OUT_W-1:0]           out_data_d;

	logic                                in_acc;
	logic                                emit_ok;
	logic [fnu_pkg::IDX_W-1:0]           slot;
	logic                                in_range;
	logic                                over_budget;
	logic                                is_big;
	logic [fnu_pkg::BYTES_W-1:0]         occ_sub;
	logic [fnu_pkg::BYTES_W-1:0]         occ_add;

	logic                                scan_start;
	logic                                nu_re;
	logic [fnu_pkg::IDX_W-1:0]           nu_raddr;
	logic [fnu_pkg::TIME_W-1:0]          nu_rdata;
	logic                                nu_we;
	logic                                size_we;
	logic [fnu_pkg::SIZE_W-1:0]          size_rdata;
	fnu_pkg::scan_res_t                  scan_res;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign emit_ok  = !out_vld_q || m_tready;

	// Slot decode and budget checks.
	assign slot        = id_q[fnu_pkg::IDX_W-1:0];
	assign in_range    = (7'(id_q) < 7'(fnu_pkg::NUM_CHUNKS));
	assign is_big      = ((fnu_pkg::BYTES_W)'(size_q) > budget_q);
	assign over_budget = (((fnu_pkg::BYTES_W+1)'(occupied_q) +
		(fnu_pkg::BYTES_W+1)'(size_q)) > (fnu_pkg::BYTES_W+1)'(budget_q));
	assign occ_sub = occupied_q - (fnu_pkg::BYTES_W)'(size_rdata);
	assign occ_add = occupied_q + (fnu_pkg::BYTES_W)'(size_q);

	assign scan_start = (state_q == ST_CHECK) && over_budget && (|present_q);
	assign nu_we      = ((state_q == ST_HIT) || (state_q == ST_STORE)) && emit_ok;
	assign size_we    = (state_q == ST_STORE) && emit_ok;

	// Next-use store, read only by the victim search.
	fnu_ram #(
		.WIDTH (fnu_pkg::TIME_W),
		.DEPTH (fnu_pkg::NUM_CHUNKS)
	) u_nu_ram (
		.clk   (clk),
		.we    (nu_we),
		.waddr (slot),
		.wdata (nu_q),
		.re    (nu_re),
		.raddr (nu_raddr),
		.rdata (nu_rdata)
	);

	// Size store, read once per eviction at the victim.
	fnu_ram #(
		.WIDTH (fnu_pkg::SIZE_W),
		.DEPTH (fnu_pkg::NUM_CHUNKS)
	) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (slot),
		.wdata (size_q),
		.re    (state_q == ST_SIZE),
		.raddr (scan_res.victim),
		.rdata (size_rdata)
	);

	fnu_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.present (present_q),
		.rdata   (nu_rdata),
		.rd_en   (nu_re),
		.rd_addr (nu_raddr),
		.res     (scan_res)
	);

	// Budget register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	// Captured input transaction.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q   <= s_tdata[5:0];
			size_q <= s_tdata[37:6];
			nu_q   <= s_tdata[69:38];
		end
	end

	// Sequencer, residency flags, resident bytes and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			present_q    <= '0;
			occupied_q   <= '0;
			miss_cnt_q   <= '0;
			miss_bytes_q <= '0;
			big_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (in_range && present_q[slot]) begin
						state_q <= ST_HIT;
					end else begin
						miss_cnt_q   <= miss_cnt_q + 1'b1;
						miss_bytes_q <= miss_bytes_q + (fnu_pkg::CNT_W)'(size_q);
						big_q        <= is_big;
						state_q      <= (in_range && !is_big) ? ST_CHECK : ST_OUTCOME;
					end
				end
				ST_HIT, ST_OUTCOME: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (scan_start) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_STORE;
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					present_q[scan_res.victim] <= 1'b0;
					state_q <= ST_EVICT;
				end
				ST_EVICT: begin
					if (emit_ok) begin
						occupied_q <= occ_sub;
						state_q    <= ST_CHECK;
					end
				end
				ST_STORE: begin
					if (emit_ok) begin
						present_q[slot] <= 1'b1;
						occupied_q      <= occ_add;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_ok) begin
			out_vld_q <= (state_q == ST_HIT) || (state_q == ST_OUTCOME) ||
				(state_q == ST_EVICT) || (state_q == ST_STORE);
		end
	end

	// Next output payload: one result per emitting state.
	always_comb begin
		out_kind_d = fnu_pkg::KIND_ACCESS;
		out_last_d = 1'b1;
		out_data_d = {miss_bytes_q, miss_cnt_q, occupied_q, 1'b0, 1'b0,
			(fnu_pkg::ID_W)'(0)};
		case (state_q)
			ST_HIT: begin
				out_data_d[6] = 1'b1;
			end
			ST_OUTCOME: begin
				out_data_d[7] = big_q;
			end
			ST_EVICT: begin
				out_kind_d        = fnu_pkg::KIND_EVICT;
				out_last_d        = 1'b0;
				out_data_d[5:0]   = (fnu_pkg::ID_W)'(scan_res.victim);
				out_data_d[55:8]  = occ_sub;
			end
			ST_STORE: begin
				out_data_d[55:8]  = occ_add;
			end
			default: begin
			end
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit_ok) begin
			out_kind_q <= out_kind_d;
			out_last_q <= out_last_d;
			out_data_q <= out_data_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// The chosen victim is a resident chunk.
	a_victim_resident: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_res.done) |-> present_q[scan_res.victim])
		else $error("victim search picked a chunk that is not resident");

	// A chunk is stored only once it fits within the budget.
	a_store_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE) |-> !over_budget)
		else $error("chunk stored while over the byte budget");

	// Only the access outcome closes a run.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == fnu_pkg::KIND_ACCESS)))
		else $error("tlast does not match the report kind");

	// No new transaction is taken while a search is in progress.
	a_no_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> (state_q == ST_SCAN || state_q == ST_SIZE))
		else $error("search left without a victim read");
`endif

endmodule

>>> bench/testbench.sv
// Testbench of the furthest-next-use byte budget evictor, checked against its own predictor.
`timescale 1ns / 1ps

module testbench;

	// Time value that means the chunk is never referenced again.
	localparam logic [fnu_pkg::TIME_W-1:0] NEVER_AGAIN = '1;
	// Bit positions of the result fields in m_tdata.
	localparam int HIT_BIT      = fnu_pkg::ID_W;
	localparam int BIG_BIT      = fnu_pkg::ID_W + 1;
	localparam int RESIDENT_LO  = fnu_pkg::ID_W + 2;
	localparam int MISSES_LO    = RESIDENT_LO + fnu_pkg::BYTES_W;
	localparam int MBYTES_LO    = MISSES_LO + fnu_pkg::CNT_W;
	// Cycles without any transaction before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 5000;
	// Cycles allowed after the last result before the block is treated as idle.
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASES         = 9;
	localparam int PHASE_ITEMS    = 52;
	localparam int MAX_PRINTED    = 200;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_PERIODIC
	} ready_pattern_t;

	// One result as the block should present it.
	typedef struct packed {
		logic                        kind;
		logic [fnu_pkg::ID_W-1:0]    victim;
		logic                        hit;
		logic                        big;
		logic [fnu_pkg::BYTES_W-1:0] resident;
		logic [fnu_pkg::CNT_W-1:0]   misses;
		logic [fnu_pkg::CNT_W-1:0]   miss_bytes;
		logic                        last;
	} report_t;

	// Tracks residency under the byte budget and holds the reports still to come.
	class evict_tracker;
		logic [fnu_pkg::BYTES_W-1:0] budget = '0;
		bit                          held [fnu_pkg::NUM_CHUNKS];
		logic [fnu_pkg::TIME_W-1:0]  nu_held [fnu_pkg::NUM_CHUNKS];
		logic [fnu_pkg::SIZE_W-1:0]  held_size [fnu_pkg::NUM_CHUNKS];
		logic [fnu_pkg::BYTES_W-1:0] resident = '0;
		logic [fnu_pkg::CNT_W-1:0]   misses = '0;
		logic [fnu_pkg::CNT_W-1:0]   miss_bytes = '0;
		report_t                     awaited [$];
		int                          errors = 0;

		function void set_budget(logic [fnu_pkg::BYTES_W-1:0] value);
			budget = value;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void push_report(logic kind, logic [fnu_pkg::ID_W-1:0] victim, logic hit,
				logic big, logic last);
			report_t r;
			r.kind = kind;
			r.victim = victim;
			r.hit = hit;
			r.big = big;
			r.resident = resident;
			r.misses = misses;
			r.miss_bytes = miss_bytes;
			r.last = last;
			awaited.push_back(r);
		endfunction

		// Works out every report that one accepted reference causes.
		function void note_reference(logic [fnu_pkg::ID_W-1:0] id,
				logic [fnu_pkg::SIZE_W-1:0] size, logic [fnu_pkg::TIME_W-1:0] nu);
			int                         victim;
			logic [fnu_pkg::TIME_W-1:0] best;
			logic                       big;
			if (int'(id) < fnu_pkg::NUM_CHUNKS && held[id]) begin
				nu_held[id] = nu;
				push_report(fnu_pkg::KIND_ACCESS, '0, 1'b1, 1'b0, 1'b1);
				return;
			end
			misses = misses + 1;
			miss_bytes = miss_bytes + fnu_pkg::CNT_W'(size);
			big = fnu_pkg::BYTES_W'(size) > budget;
			if (int'(id) < fnu_pkg::NUM_CHUNKS && !big) begin
				// Evict the furthest next use, lowest id on ties, until the chunk fits.
				while (fnu_pkg::CNT_W'(resident) + fnu_pkg::CNT_W'(size) >
						fnu_pkg::CNT_W'(budget)) begin
					victim = -1;
					best = '0;
					for (int k = 0; k < fnu_pkg::NUM_CHUNKS; k++) begin
						if (held[k] && (victim < 0 || nu_held[k] > best)) begin
							victim = k;
							best = nu_held[k];
						end
					end
					if (victim < 0)
						break;
					held[victim] = 1'b0;
					resident = resident - fnu_pkg::BYTES_W'(held_size[victim]);
					push_report(fnu_pkg::KIND_EVICT, fnu_pkg::ID_W'(victim), 1'b0, 1'b0,
						1'b0);
				end
				held[id] = 1'b1;
				held_size[id] = size;
				nu_held[id] = nu;
				resident = resident + fnu_pkg::BYTES_W'(size);
			end
			push_report(fnu_pkg::KIND_ACCESS, '0, 1'b0, big, 1'b1);
		endfunction

		function void compare_field(string name, logic [fnu_pkg::CNT_W-1:0] want,
				logic [fnu_pkg::CNT_W-1:0] seen);
			if (want !== seen) begin
				errors++;
				// Further mismatches are counted but not printed.
				if (errors <= MAX_PRINTED)
					$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want,
						seen);
			end
		endfunction

		// Compares one accepted result with the oldest report awaited.
		function void check_report(logic kind, logic [fnu_pkg::OUT_W-1:0] data, logic last);
			report_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0b data %0h",
					$time, kind, data);
				return;
			end
			want = awaited.pop_front();
			compare_field("report_kind", want.kind, kind);
			compare_field("victim_id", want.victim, data[fnu_pkg::ID_W-1:0]);
			compare_field("was_hit", want.hit, data[HIT_BIT]);
			compare_field("too_large", want.big, data[BIG_BIT]);
			compare_field("bytes_resident", want.resident,
				data[RESIDENT_LO +: fnu_pkg::BYTES_W]);
			compare_field("miss_total", want.misses, data[MISSES_LO +: fnu_pkg::CNT_W]);
			compare_field("missed_byte_total", want.miss_bytes,
				data[MBYTES_LO +: fnu_pkg::CNT_W]);
			compare_field("last_of_run", want.last, last);
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [fnu_pkg::BYTES_W-1:0] cfg_wdata = '0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [fnu_pkg::IN_W-1:0]    s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [fnu_pkg::OUT_W-1:0]   m_tdata;
	logic                        m_tuser;
	logic                        m_tlast;

	evict_tracker                tracker = new;
	logic [fnu_pkg::TIME_W-1:0]  ref_index = '0;
	int                          burst_left = 1;
	int                          idle_cycles = 0;
	ready_pattern_t              ready_pattern = READY_ALWAYS;
	int                          pattern_left = 0;
	int                          pattern_phase = 0;

	furthest_next_use_byte_budget_evictor_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #1 clk = ~clk;

	// The receiver switches between always ready, random stalls and a periodic pattern.
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			ready_pattern <= ready_pattern_t'($urandom_range(0, 2));
			pattern_left <= $urandom_range(50, 400);
		end else begin
			pattern_left <= pattern_left - 1;
		end
		pattern_phase <= pattern_phase + 1;
		case (ready_pattern)
			READY_ALWAYS: begin
				m_tready <= 1'b1;
			end
			READY_RANDOM: begin
				m_tready <= $urandom_range(0, 2) != 0;
			end
			default: begin
				m_tready <= (pattern_phase % 7) < 4;
			end
		endcase
	end

	// Every result transaction is checked against the predictor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_report(m_tuser, m_tdata, m_tlast);
	end

	// The watchdog ends a run in which no transaction happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic sender_pause(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Offers one reference and waits for its transaction; bursts end in a random gap.
	task automatic send_reference(input logic [fnu_pkg::ID_W-1:0] id,
			input logic [fnu_pkg::SIZE_W-1:0] size, input logic [fnu_pkg::TIME_W-1:0] nu);
		s_tvalid <= 1'b1;
		s_tdata <= fnu_pkg::IN_W'({nu, size, id});
		do @(posedge clk); while (!s_tready);
		tracker.note_reference(id, size, nu);
		ref_index = ref_index + 1;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			sender_pause($urandom_range(1, 12));
		end
	endtask

	// Holds the sender until every awaited report has arrived and the block is idle.
	task automatic settle();
		if (s_tvalid)
			sender_pause(1);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_budget(input logic [fnu_pkg::BYTES_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_budget(value);
	endtask

	initial begin
		logic [fnu_pkg::ID_W-1:0]    trace [$];
		logic [fnu_pkg::TIME_W-1:0]  trace_nu;
		logic [fnu_pkg::TIME_W-1:0]  phase_base;
		logic [fnu_pkg::SIZE_W-1:0]  size_pick [fnu_pkg::NUM_CHUNKS];
		logic [fnu_pkg::BYTES_W-1:0] phase_budget [PHASES];
		logic [fnu_pkg::SIZE_W-1:0]  phase_size_hi [PHASES];
		logic [fnu_pkg::SIZE_W-1:0]  sz;
		logic [63:0]                 wide;
		int                          ws_hi;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero budget after reset: a zero-byte chunk fits, anything larger is too large.
		send_reference(6'd0, 32'd0, 32'd5);
		send_reference(6'd0, 32'd0, 32'd7);
		send_reference(6'd1, 32'd1, 32'd0);

		// Largest budget with the largest chunks and times.
		write_budget('1);
		send_reference(6'd63, 32'hFFFF_FFFF, NEVER_AGAIN);
		send_reference(6'd62, 32'hFFFF_FFFF, 32'd0);
		send_reference(6'd63, 32'h0, 32'd3);

		// Budget lowered far below the resident bytes: the next storing miss empties it.
		write_budget(48'd100);
		send_reference(6'd10, 32'd100, 32'd50);
		send_reference(6'd12, 32'd101, 32'd9);
		send_reference(6'd20, 32'd0, 32'd50);
		// Tie on the furthest next use goes to the lowest id.
		send_reference(6'd5, 32'd10, 32'd1);
		// Exactly at the budget, then a chunk never used again goes first.
		send_reference(6'd6, 32'd90, NEVER_AGAIN);
		send_reference(6'd7, 32'd1, 32'd2);
		send_reference(6'd7, 32'd1, NEVER_AGAIN);

		// Hits after a lowered budget change nothing; the next miss evicts until it fits.
		write_budget(48'd5);
		send_reference(6'd7, 32'd1, 32'd4);
		send_reference(6'd5, 32'd10, 32'd3);
		send_reference(6'd8, 32'd5, 32'd0);
		send_reference(6'd9, 32'd6, 32'd0);

		// Random phases: traces with true next-use times, some noise on size and time.
		phase_budget[0] = '1;            phase_size_hi[0] = 32'hFFFF_FFFF;
		phase_budget[1] = 48'h1_0000_0000; phase_size_hi[1] = 32'hFFFF_FFFF;
		phase_budget[2] = 48'd1000;      phase_size_hi[2] = 32'd400;
		phase_budget[3] = 48'd5000;      phase_size_hi[3] = 32'd300;
		phase_budget[4] = 48'd1000;      phase_size_hi[4] = 32'd1200;
		phase_budget[5] = 48'd64;        phase_size_hi[5] = 32'd8;
		phase_budget[6] = 48'd0;         phase_size_hi[6] = 32'd1;
		phase_budget[7] = fnu_pkg::BYTES_W'($urandom_range(16, 100000));
		phase_size_hi[7] = fnu_pkg::SIZE_W'(phase_budget[7] / 6);
		wide = {$urandom(), $urandom()};
		phase_budget[8] = wide[fnu_pkg::BYTES_W-1:0];
		phase_size_hi[8] = 32'hFFFF_FFFF;

		for (int p = 0; p < PHASES; p++) begin
			write_budget(phase_budget[p]);
			ws_hi = $urandom_range(3, fnu_pkg::NUM_CHUNKS - 1);
			for (int k = 0; k < fnu_pkg::NUM_CHUNKS; k++)
				size_pick[k] = $urandom_range(0, phase_size_hi[p]);
			trace.delete();
			for (int i = 0; i < PHASE_ITEMS; i++)
				trace.push_back(fnu_pkg::ID_W'($urandom_range(0, ws_hi)));
			phase_base = ref_index;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				trace_nu = NEVER_AGAIN;
				for (int j = i + 1; j < PHASE_ITEMS; j++) begin
					if (trace[j] == trace[i]) begin
						trace_nu = phase_base + fnu_pkg::TIME_W'(j);
						break;
					end
				end
				if ($urandom_range(0, 7) == 0)
					trace_nu = $urandom();
				sz = size_pick[trace[i]];
				if ($urandom_range(0, 15) == 0)
					sz = $urandom();
				send_reference(trace[i], sz, trace_nu);
				// Now and then the sender waits for every result before going on.
				if ($urandom_range(0, 39) == 0)
					settle();
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> furthest_next_use_byte_budget_evictor_top.f
rtl/fnu_pkg.sv
rtl/fnu_ram.sv
rtl/fnu_scan.sv
rtl/furthest_next_use_byte_budget_evictor_top.sv
bench/testbench.sv
